### hw/rtl/psdl_pkg.sv
package psdl_pkg;

  localparam int MAX_DELAY_DEF = 1024;

  // reset values of the configuration registers
  localparam int DELAY_LENGTH_RST = 218;
  localparam int DECAY_GAIN_RST = 65208;

  // Q0.16 mix weights, they add up to one
  localparam int MIX_CUR_Q16 = 42598;
  localparam int MIX_NEXT_Q16 = 22938;

  localparam logic CFG_DELAY_LENGTH = 1'b0;
  localparam logic CFG_DECAY_GAIN = 1'b1;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  typedef enum logic [6:0] {
    S_CLR  = 7'b0000001,
    S_IDLE = 7'b0000010,
    S_CUR  = 7'b0000100,
    S_NXT  = 7'b0001000,
    S_MIX  = 7'b0010000,
    S_GAIN = 7'b0100000,
    S_WB   = 7'b1000000
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load_wr;
    logic tick_start;
    logic cap_cur;
    logic cap_nxt;
    logic mix;
    logic gain;
    logic wb;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/psdl_ram.sv
module psdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/psdl_dp.sv
module psdl_dp #(
  parameter int MAX_DELAY = psdl_pkg::MAX_DELAY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  psdl_pkg::cmd_t      cmd,
  output psdl_pkg::sts_t      sts,
  input  logic [9:0]          in_load_index,
  input  logic signed [15:0]  in_load_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [15:0]  out_output_sample,
  input  logic                cfg_wr_en,
  input  logic                cfg_index,
  input  logic [15:0]         cfg_wdata
);

  localparam int AW = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int LEN_MAX = (MAX_DELAY < 2047) ? MAX_DELAY : 2047;
  localparam int LW = $clog2(LEN_MAX + 1);
  localparam int PW = $clog2(LEN_MAX);

  function automatic logic [LW-1:0] clamp_len(input logic [10:0] raw);
    logic [LW-1:0] r;
    if (32'(raw) < 32'd2) begin
      r = LW'(2);
    end else if (32'(raw) > 32'(MAX_DELAY)) begin
      r = LW'(MAX_DELAY);
    end else begin
      r = LW'(raw);
    end
    return r;
  endfunction

  logic [LW-1:0] len_r;
  logic [15:0] gain_r;
  logic [PW-1:0] rd_pos_r;
  logic [PW-1:0] pos_r;
  logic [PW-1:0] nxt_pos_r;
  logic [AW-1:0] clr_addr_r;

  logic [PW-1:0] pos_eff;
  logic [PW:0] pos_inc;
  logic [PW-1:0] nxt_pos;

  logic ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [15:0] ram_rdata;
  logic load_in_range;

  logic signed [32:0] pc_r;
  logic signed [32:0] pn_r;
  logic signed [33:0] mix_sum;
  logic mix_rnd;
  logic signed [16:0] mix_r;
  logic signed [33:0] gp_r;
  logic gp_rnd;
  logic signed [15:0] upd;
  logic signed [15:0] sample_r;

  logic out_valid_r;
  logic out_valid_nxt;
  logic signed [15:0] out_sample_r;

  // position wraps back to the start of the active line
  assign pos_eff = (32'(rd_pos_r) >= 32'(len_r)) ? '0 : rd_pos_r;
  assign pos_inc = {1'b0, pos_eff} + (PW + 1)'(1);
  assign nxt_pos = (32'(pos_inc) >= 32'(len_r)) ? '0 : PW'(pos_inc);

  assign load_in_range = 32'(in_load_index) < 32'(MAX_DELAY);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = clr_addr_r;
    ram_wdata = '0;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
    end else if (cmd.wb) begin
      ram_we = 1'b1;
      ram_waddr = AW'(pos_r);
      ram_wdata = upd;
    end else if (cmd.load_wr && load_in_range) begin
      ram_we = 1'b1;
      ram_waddr = AW'(in_load_index);
      ram_wdata = in_load_value;
    end
  end

  // current entry is read on the accepting edge, the next one in the cycle after
  assign ram_raddr = cmd.cap_cur ? AW'(nxt_pos_r) : AW'(pos_eff);

  psdl_ram #(
    .WIDTH(16),
    .DEPTH(MAX_DELAY)
  ) u_line (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= clamp_len(11'(psdl_pkg::DELAY_LENGTH_RST));
      gain_r <= 16'(psdl_pkg::DECAY_GAIN_RST);
      rd_pos_r <= '0;
      clr_addr_r <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (cmd.wb) begin
        rd_pos_r <= nxt_pos_r;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          psdl_pkg::CFG_DELAY_LENGTH: begin
            len_r <= clamp_len(cfg_wdata[10:0]);
            rd_pos_r <= '0;
          end
          psdl_pkg::CFG_DECAY_GAIN: begin
            gain_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign sts.clr_last = clr_addr_r == AW'(MAX_DELAY - 1);

  // truncation toward zero of the Q16 products
  assign mix_sum = 34'(pc_r) + 34'(pn_r);
  assign mix_rnd = mix_sum[33] && (mix_sum[15:0] != 16'd0);
  assign gp_rnd = gp_r[33] && (gp_r[15:0] != 16'd0);
  assign upd = 16'(gp_r >>> 16) + 16'(gp_rnd);

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      pos_r <= pos_eff;
      nxt_pos_r <= nxt_pos;
    end
    if (cmd.cap_cur) begin
      pc_r <= 33'($signed(ram_rdata)) * 33'(psdl_pkg::MIX_CUR_Q16);
      sample_r <= (ram_rdata == 16'h8000) ? 16'sh8001 : $signed(ram_rdata);
    end
    if (cmd.cap_nxt) begin
      pn_r <= 33'($signed(ram_rdata)) * 33'(psdl_pkg::MIX_NEXT_Q16);
    end
    if (cmd.mix) begin
      mix_r <= 17'(mix_sum >>> 16) + 17'(mix_rnd);
    end
    if (cmd.gain) begin
      gp_r <= 34'(mix_r) * 34'($signed({1'b0, gain_r}));
    end
    if (cmd.wb) begin
      out_sample_r <= sample_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.wb) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_output_sample = out_sample_r;

  a_pos_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rd_pos_r) < 32'(len_r))
    else $error("read position beyond active length");

  a_no_most_negative: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_sample_r != 16'sh8000)
    else $error("output sample not saturated");

  a_wb_pushes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> out_valid_r && out_sample_r == $past(sample_r))
    else $error("write-back did not deliver its sample");

endmodule

### hw/rtl/psdl_ctrl.sv
module psdl_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_operation,
  output logic           in_stall,
  input  psdl_pkg::sts_t sts,
  output psdl_pkg::cmd_t cmd
);

  psdl_pkg::state_t state_r;
  psdl_pkg::state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    case (state_r)
      psdl_pkg::S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = psdl_pkg::S_IDLE;
        end
      end
      psdl_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_operation == psdl_pkg::OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.tick_start = 1'b1;
            state_nxt = psdl_pkg::S_CUR;
          end
        end
      end
      psdl_pkg::S_CUR: begin
        cmd.cap_cur = 1'b1;
        state_nxt = psdl_pkg::S_NXT;
      end
      psdl_pkg::S_NXT: begin
        cmd.cap_nxt = 1'b1;
        state_nxt = psdl_pkg::S_MIX;
      end
      psdl_pkg::S_MIX: begin
        cmd.mix = 1'b1;
        state_nxt = psdl_pkg::S_GAIN;
      end
      psdl_pkg::S_GAIN: begin
        cmd.gain = 1'b1;
        state_nxt = psdl_pkg::S_WB;
      end
      psdl_pkg::S_WB: begin
        // hold until the output register can take the sample
        if (sts.out_free) begin
          cmd.wb = 1'b1;
          state_nxt = psdl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = psdl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psdl_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != psdl_pkg::S_IDLE;

  a_tick_reaches_wb: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick_start |-> ##5 (state_r == psdl_pkg::S_WB))
    else $error("tick did not reach write-back on time");

  a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psdl_pkg::S_CLR) && sts.clr_last |=> state_r == psdl_pkg::S_IDLE)
    else $error("clearing pass did not end");

  a_wait_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == psdl_pkg::S_WB) && !sts.out_free |=> state_r == psdl_pkg::S_WB)
    else $error("write-back left while output was full");

endmodule

### hw/rtl/plucked_string_delay_line_synth.sv
// Plucked-string voice over a circular delay line.
// Input channel (in_valid / in_stall): in_operation picks a tick, which returns one
// sample, or a load, which writes in_load_value at in_load_index and returns nothing.
// Result channel (out_valid / out_stall): one out_output_sample per tick, in order.
// Configuration (cfg_wr_en / cfg_index / cfg_wdata): index 0 sets the delay length
// (clamped to 2..MAX_DELAY) and returns the read position to the start, index 1 the
// decay gain. Write only while the block is idle.
// A load is written on the edge that accepts it. A tick runs two reads of the single
// delay-line read port, two mix products, the Q16 sum, the gain product and the
// write-back in turn through the controller, one item at a time. The sample appears
// on the result channel the cycle after the write-back.
// The output register holds a finished sample while out_stall is high; the next item
// is still taken, and a following tick waits at write-back until the register frees.
// After reset the delay line is cleared, one entry a cycle, through all MAX_DELAY entries
// (1024 by default) with in_stall high; configuration writes are taken meanwhile.
module plucked_string_delay_line_synth #(
  parameter int MAX_DELAY = psdl_pkg::MAX_DELAY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_operation,
  input  logic [9:0]         in_load_index,
  input  logic signed [15:0] in_load_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_output_sample,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_wdata
);

  psdl_pkg::cmd_t cmd;
  psdl_pkg::sts_t sts;

  psdl_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  psdl_dp #(
    .MAX_DELAY(MAX_DELAY)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_output_sample(out_output_sample),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

endmodule
